### rtl/core/slrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrd_pkg
// Shared widths, codes and controller/datapath handshake types for the
// stable level run detector.
// ----------------------------------------------------------------------------
package slrd_pkg;

   localparam int TAG_W   = 16;
   localparam int FRAME_W = 31;
   localparam int TIME_W  = 32;
   localparam int IV_W    = 16;
   localparam int LVL_W   = 13;
   localparam int CNT_W   = 16;
   localparam int TOTAL_W = 29;
   localparam int STAB_W  = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   // shared divider: magnitude of run total over count, and stability ratio
   localparam int DIV_NUM_W = 28;
   localparam int DIV_DEN_W = 16;

   localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
   localparam logic signed [LVL_W-1:0] PEAK_FLOOR = -13'sd3200;
   localparam logic signed [LVL_W-1:0] LEVEL_FLOOR = -13'sd1600;
   localparam logic [IV_W-1:0] IV_MIN = 16'd100;

   typedef enum logic [1:0] {
      OP_SILENCE = 2'd0,
      OP_OBSERVE = 2'd1,
      OP_FLUSH   = 2'd2,
      OP_UNUSED  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_MIN_LEVEL  = 2'd0,
      CSR_MAX_LEVEL  = 2'd1,
      CSR_MAX_SPREAD = 2'd2,
      CSR_MIN_COUNT  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      RUN_HOLD   = 2'd0,
      RUN_CLEAR  = 2'd1,
      RUN_START  = 2'd2,
      RUN_EXTEND = 2'd3
   } run_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CALC,
      ST_SCAN,
      ST_DECIDE,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_STAB_GO,
      ST_STAB_WAIT,
      ST_OUT
   } ctrl_state_type;

   typedef struct packed {
      logic       capture;
      logic       calc;
      logic       load_sil;
      logic       scan_step;
      logic       snapshot;
      run_op_type run_op;
      logic       div_go;
      logic       div_stab;
      logic       store_mean;
      logic       store_stab;
      logic       load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       item_bad;
      logic       scan_done;
      logic       in_window;
      logic       overlap;
      logic       run_active;
      logic       cont_ok;
      logic       spread_over;
      logic       emit_ok;
      logic       div_done;
      logic       out_free;
   } dp_status_type;

endpackage

### rtl/core/slrd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slrd_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [slrd_pkg::DIV_NUM_W-1:0] numer,
   input  logic [slrd_pkg::DIV_DEN_W-1:0] denom,
   output logic                           done,
   output logic [slrd_pkg::DIV_NUM_W-1:0] quot
);
   import slrd_pkg::*;

   localparam int STEP_W = $clog2(DIV_NUM_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_NUM_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   rem_sh;
   logic [DIV_DEN_W:0]   rem_sub;
   logic                 qbit;

   // one shift-subtract step
   always_comb begin
      rem_sh  = {rem_ff, num_ff[DIV_NUM_W-1]};
      rem_sub = rem_sh - {1'b0, den_ff};
      qbit    = (rem_sh >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = numer;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         num_in  = {num_ff[DIV_NUM_W-2:0], qbit};
         rem_in  = qbit ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // operand registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

### rtl/core/slrd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrd_ctrl
// Sequencer: takes items, walks the silence table, decides run updates and
// steps the divider for reported runs.
// ----------------------------------------------------------------------------
module slrd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  slrd_pkg::dp_status_type status,
   output slrd_pkg::ctrl_cmd_type  cmd
);
   import slrd_pkg::*;

   ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.run_op = RUN_HOLD;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            case (status.op)
               OP_SILENCE: begin
                  cmd.load_sil = 1'b1;
                  state_in     = ST_IDLE;
               end
               OP_OBSERVE: begin
                  state_in = status.item_bad ? ST_IDLE : ST_SCAN;
               end
               OP_FLUSH: begin
                  cmd.snapshot = status.emit_ok;
                  cmd.run_op   = RUN_CLEAR;
                  state_in     = status.emit_ok ? ST_MEAN_GO : ST_IDLE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               cmd.scan_step = 1'b0;
               state_in      = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_IDLE;
            if (!status.in_window || status.overlap) begin
               cmd.snapshot = status.emit_ok;
               cmd.run_op   = RUN_CLEAR;
               if (status.emit_ok) state_in = ST_MEAN_GO;
            end else if (!status.run_active) begin
               cmd.run_op = RUN_START;
            end else if (!status.cont_ok || status.spread_over) begin
               cmd.snapshot = status.emit_ok;
               cmd.run_op   = RUN_START;
               if (status.emit_ok) state_in = ST_MEAN_GO;
            end else begin
               cmd.run_op = RUN_EXTEND;
            end
         end
         ST_MEAN_GO: begin
            cmd.div_go = 1'b1;
            state_in   = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (status.div_done) begin
               cmd.store_mean = 1'b1;
               state_in       = ST_STAB_GO;
            end
         end
         ST_STAB_GO: begin
            cmd.div_go   = 1'b1;
            cmd.div_stab = 1'b1;
            state_in     = ST_STAB_WAIT;
         end
         ST_STAB_WAIT: begin
            cmd.div_stab = 1'b1;
            if (status.div_done) begin
               cmd.store_stab = 1'b1;
               state_in       = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### rtl/core/slrd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrd_datapath
// Settings, silence table, run state, report snapshot, divider and the
// result output register.
// ----------------------------------------------------------------------------
module slrd_datapath #(
   parameter int SILENCE_DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  slrd_pkg::ctrl_cmd_type                cmd,
   output slrd_pkg::dp_status_type               status,
   input  logic                                  csr_valid,
   input  logic [slrd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [slrd_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic [1:0]                            req_opcode,
   input  logic [slrd_pkg::TAG_W-1:0]            req_source_tag,
   input  logic [slrd_pkg::TAG_W-1:0]            req_lineage_tag,
   input  logic [slrd_pkg::FRAME_W-1:0]          req_start_frame,
   input  logic [slrd_pkg::FRAME_W-1:0]          req_end_frame,
   input  logic [slrd_pkg::TIME_W-1:0]           req_pts_ms,
   input  logic [slrd_pkg::IV_W-1:0]             req_interval_ms,
   input  logic signed [slrd_pkg::LVL_W-1:0]     req_level,
   input  logic signed [slrd_pkg::LVL_W-1:0]     req_true_peak,
   input  logic                                  req_peak_valid,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [slrd_pkg::TAG_W-1:0]            rsp_run_lineage,
   output logic [slrd_pkg::FRAME_W-1:0]          rsp_run_start,
   output logic [slrd_pkg::FRAME_W-1:0]          rsp_run_end,
   output logic [slrd_pkg::CNT_W-1:0]            rsp_run_length,
   output logic signed [slrd_pkg::LVL_W-1:0]     rsp_level_mean,
   output logic signed [slrd_pkg::LVL_W-1:0]     rsp_level_min,
   output logic signed [slrd_pkg::LVL_W-1:0]     rsp_level_max,
   output logic [slrd_pkg::LVL_W-1:0]            rsp_level_spread,
   output logic [slrd_pkg::STAB_W-1:0]           rsp_stability,
   output logic signed [slrd_pkg::LVL_W-1:0]     rsp_peak_max,
   output logic                                  rsp_peak_seen
);
   import slrd_pkg::*;

   localparam int IDX_W = (SILENCE_DEPTH > 1) ? $clog2(SILENCE_DEPTH) : 1;
   localparam int USED_W = $clog2(SILENCE_DEPTH + 1);
   localparam logic [USED_W-1:0] USED_FULL = USED_W'(SILENCE_DEPTH);

   // settings
   logic signed [11:0] min_level_ff;
   logic signed [11:0] max_level_ff;
   logic [8:0]         max_spread_ff;
   logic [9:0]         min_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_level_ff  <= -12'sd1040;
         max_level_ff  <= -12'sd400;
         max_spread_ff <= 9'd80;
         min_count_ff  <= 10'd4;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_LEVEL:  min_level_ff  <= csr_wdata;
            CSR_MAX_LEVEL:  max_level_ff  <= csr_wdata;
            CSR_MAX_SPREAD: max_spread_ff <= csr_wdata[8:0];
            CSR_MIN_COUNT:  min_count_ff  <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // clamped settings
   logic signed [LVL_W-1:0] win_lo, win_hi, lo_ext, hi_ext;
   logic [8:0]              ms_cl;
   logic [9:0]              need_cl;

   always_comb begin
      lo_ext  = LVL_W'(min_level_ff);
      hi_ext  = LVL_W'(max_level_ff);
      win_lo  = (lo_ext < LEVEL_FLOOR) ? LEVEL_FLOOR : ((lo_ext > 0) ? '0 : lo_ext);
      win_hi  = (hi_ext < LEVEL_FLOOR) ? LEVEL_FLOOR : ((hi_ext > 0) ? '0 : hi_ext);
      ms_cl   = (max_spread_ff < 9'd2) ? 9'd2 :
                ((max_spread_ff > 9'd480) ? 9'd480 : max_spread_ff);
      need_cl = (min_count_ff < 10'd2) ? 10'd2 :
                ((min_count_ff > 10'd1000) ? 10'd1000 : min_count_ff);
   end

   // captured item
   logic [1:0]              it_op_ff;
   logic [TAG_W-1:0]        it_src_ff, it_lin_ff;
   logic [FRAME_W-1:0]      it_sf_ff, it_ef_ff;
   logic [TIME_W-1:0]       it_pts_ff;
   logic [IV_W-1:0]         it_iv_ff;
   logic signed [LVL_W-1:0] it_lvl_ff, it_tp_ff;
   logic                    it_pv_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         it_op_ff  <= req_opcode;
         it_src_ff <= req_source_tag;
         it_lin_ff <= req_lineage_tag;
         it_sf_ff  <= req_start_frame;
         it_ef_ff  <= req_end_frame;
         it_pts_ff <= req_pts_ms;
         it_iv_ff  <= req_interval_ms;
         it_lvl_ff <= req_level;
         it_tp_ff  <= req_true_peak;
         it_pv_ff  <= req_peak_valid;
      end
   end

   // run state
   logic [CNT_W-1:0]          run_count_ff;
   logic [TAG_W-1:0]          run_tag_ff;
   logic [FRAME_W-1:0]        run_first_ff, run_last_ff;
   logic [TIME_W-1:0]         run_time_ff;
   logic [IV_W-1:0]           run_iv_ff;
   logic signed [LVL_W-1:0]   run_low_ff, run_high_ff, run_peak_ff;
   logic signed [TOTAL_W-1:0] run_total_ff;
   logic                      run_seen_ff;

   // time gap check, split over the products and the compare
   logic [IV_W-1:0]   iv_max;
   logic [TIME_W-1:0] gap;
   logic [38:0]       gap100_ff;
   logic [23:0]       lim_ff;
   logic              order_ok_ff;
   logic              in_win_ff;

   always_comb begin
      iv_max = (it_iv_ff > run_iv_ff) ? it_iv_ff : run_iv_ff;
      gap    = it_pts_ff - run_time_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         gap100_ff   <= 39'(gap) * 39'd100;
         lim_ff      <= 24'(iv_max) * 24'd155 + 24'd100;
         order_ok_ff <= (it_lin_ff == run_tag_ff) && (it_pts_ff > run_time_ff);
         in_win_ff   <= (it_lvl_ff >= win_lo) && (it_lvl_ff <= win_hi);
      end
   end

   // silence table
   logic [TAG_W-1:0]   sil_src_mem [SILENCE_DEPTH];
   logic [FRAME_W-1:0] sil_beg_mem [SILENCE_DEPTH];
   logic [FRAME_W-1:0] sil_fin_mem [SILENCE_DEPTH];
   logic [USED_W-1:0]  used_ff;
   logic [USED_W-1:0]  scan_idx_ff;
   logic               pend_ff;
   logic               overlap_ff;
   logic [TAG_W-1:0]   rd_src_ff;
   logic [FRAME_W-1:0] rd_beg_ff, rd_fin_ff;
   logic               hit;

   always_ff @(posedge clock) begin
      if (cmd.load_sil && (it_ef_ff >= it_sf_ff) && (used_ff != USED_FULL)) begin
         sil_src_mem[used_ff[IDX_W-1:0]] <= it_src_ff;
         sil_beg_mem[used_ff[IDX_W-1:0]] <= it_sf_ff;
         sil_fin_mem[used_ff[IDX_W-1:0]] <= it_ef_ff;
      end
      rd_src_ff <= sil_src_mem[scan_idx_ff[IDX_W-1:0]];
      rd_beg_ff <= sil_beg_mem[scan_idx_ff[IDX_W-1:0]];
      rd_fin_ff <= sil_fin_mem[scan_idx_ff[IDX_W-1:0]];
   end

   // overlap test against the entry read last cycle
   always_comb begin
      hit = (rd_src_ff == it_src_ff) &&
            (((it_sf_ff < rd_fin_ff) && (it_ef_ff > rd_beg_ff)) ||
             ((rd_beg_ff == rd_fin_ff) && (it_sf_ff <= rd_beg_ff) &&
              (it_ef_ff > rd_beg_ff)));
   end

   // table fill count and scan walk
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         scan_idx_ff <= '0;
         pend_ff     <= 1'b0;
         overlap_ff  <= 1'b0;
      end else begin
         if (cmd.load_sil && (it_ef_ff >= it_sf_ff) && (used_ff != USED_FULL)) begin
            used_ff <= used_ff + 1'b1;
         end
         if (cmd.calc) begin
            scan_idx_ff <= '0;
            pend_ff     <= 1'b0;
            overlap_ff  <= 1'b0;
         end else if (cmd.scan_step) begin
            pend_ff <= (scan_idx_ff != used_ff);
            if (scan_idx_ff != used_ff) scan_idx_ff <= scan_idx_ff + 1'b1;
            if (pend_ff && hit) overlap_ff <= 1'b1;
         end
      end
   end

   // run update
   logic signed [LVL_W-1:0] nlo, nhi, peak_start;
   logic signed [LVL_W:0]   span;

   always_comb begin
      nlo        = (it_lvl_ff < run_low_ff) ? it_lvl_ff : run_low_ff;
      nhi        = (it_lvl_ff > run_high_ff) ? it_lvl_ff : run_high_ff;
      span       = (LVL_W+1)'(nhi) - (LVL_W+1)'(nlo);
      peak_start = (it_pv_ff && (it_tp_ff > PEAK_FLOOR)) ? it_tp_ff : PEAK_FLOOR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_count_ff <= '0;
      end else begin
         case (cmd.run_op)
            RUN_CLEAR: run_count_ff <= '0;
            RUN_START: run_count_ff <= CNT_W'(1);
            RUN_EXTEND: begin
               if (run_count_ff != COUNT_MAX) run_count_ff <= run_count_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.run_op)
         RUN_START: begin
            run_tag_ff   <= it_lin_ff;
            run_first_ff <= it_sf_ff;
            run_last_ff  <= it_ef_ff;
            run_time_ff  <= it_pts_ff;
            run_iv_ff    <= it_iv_ff;
            run_low_ff   <= it_lvl_ff;
            run_high_ff  <= it_lvl_ff;
            run_total_ff <= TOTAL_W'(it_lvl_ff);
            run_peak_ff  <= peak_start;
            run_seen_ff  <= it_pv_ff;
         end
         RUN_EXTEND: begin
            if (run_count_ff != COUNT_MAX) run_total_ff <= run_total_ff + TOTAL_W'(it_lvl_ff);
            run_low_ff  <= nlo;
            run_high_ff <= nhi;
            run_last_ff <= it_ef_ff;
            run_time_ff <= it_pts_ff;
            run_iv_ff   <= it_iv_ff;
            if (it_pv_ff) begin
               if (it_tp_ff > run_peak_ff) run_peak_ff <= it_tp_ff;
               run_seen_ff <= 1'b1;
            end
         end
         default: ;
      endcase
   end

   // report snapshot
   logic [TAG_W-1:0]        rep_tag_ff;
   logic [FRAME_W-1:0]      rep_first_ff, rep_last_ff;
   logic [CNT_W-1:0]        rep_count_ff;
   logic                    rep_neg_ff;
   logic [DIV_NUM_W-1:0]    rep_mag_ff;
   logic signed [LVL_W-1:0] rep_low_ff, rep_high_ff, rep_peak_ff, rep_mean_ff;
   logic                    rep_seen_ff;
   logic [8:0]              rep_ms_ff;
   logic [STAB_W-1:0]       rep_stab_ff;
   logic [LVL_W-1:0]        rep_spread;
   logic [TOTAL_W-1:0]      total_abs;

   always_comb begin
      total_abs  = run_total_ff[TOTAL_W-1] ? TOTAL_W'(-run_total_ff) : TOTAL_W'(run_total_ff);
      rep_spread = LVL_W'(rep_high_ff - rep_low_ff);
   end

   // divider operands
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quot, div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [8:0]           stab_diff;

   always_comb begin
      stab_diff = rep_ms_ff - rep_spread[8:0];
      if (cmd.div_stab) begin
         div_num = (rep_spread < LVL_W'(rep_ms_ff)) ? DIV_NUM_W'({stab_diff, 8'd0}) : '0;
         div_den = DIV_DEN_W'(rep_ms_ff);
      end else begin
         div_num = rep_mag_ff;
         div_den = rep_count_ff;
      end
   end

   slrd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_go),
      .numer (div_num),
      .denom (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.snapshot) begin
         rep_tag_ff   <= run_tag_ff;
         rep_first_ff <= run_first_ff;
         rep_last_ff  <= run_last_ff;
         rep_count_ff <= run_count_ff;
         rep_neg_ff   <= run_total_ff[TOTAL_W-1];
         rep_mag_ff   <= DIV_NUM_W'(total_abs);
         rep_low_ff   <= run_low_ff;
         rep_high_ff  <= run_high_ff;
         rep_peak_ff  <= run_peak_ff;
         rep_seen_ff  <= run_seen_ff;
         rep_ms_ff    <= ms_cl;
      end
      if (cmd.store_mean) begin
         rep_mean_ff <= rep_neg_ff ? LVL_W'(-div_quot) : LVL_W'(div_quot);
      end
      if (cmd.store_stab) begin
         rep_stab_ff <= div_quot[STAB_W-1:0];
      end
   end

   // result output register
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_run_lineage  <= rep_tag_ff;
         rsp_run_start    <= rep_first_ff;
         rsp_run_end      <= rep_last_ff;
         rsp_run_length   <= rep_count_ff;
         rsp_level_mean   <= rep_mean_ff;
         rsp_level_min    <= rep_low_ff;
         rsp_level_max    <= rep_high_ff;
         rsp_level_spread <= rep_spread;
         rsp_stability    <= rep_stab_ff;
         rsp_peak_max     <= rep_peak_ff;
         rsp_peak_seen    <= rep_seen_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // status back to the sequencer
   always_comb begin
      status             = '0;
      status.op          = opcode_type'(it_op_ff);
      status.item_bad    = (it_ef_ff <= it_sf_ff) || (it_iv_ff < IV_MIN);
      status.scan_done   = (scan_idx_ff == used_ff) && !pend_ff;
      status.in_window   = in_win_ff;
      status.overlap     = overlap_ff;
      status.run_active  = (run_count_ff != '0);
      status.cont_ok     = order_ok_ff && (gap100_ff <= 39'(lim_ff));
      status.spread_over = (span > (LVL_W+1)'(ms_cl));
      status.emit_ok     = (run_count_ff != '0) && (run_count_ff >= CNT_W'(need_cl));
      status.div_done    = div_done;
      status.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_FULL)
      else $error("silence fill count past table depth");

   a_run_order: assert property (@(posedge clock) disable iff (reset)
      (run_count_ff != '0) |-> (run_low_ff <= run_high_ff))
      else $error("active run has low above high");

   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending transfer");

   a_out_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

### rtl/core/stable_level_run_detector_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_level_run_detector_top
// Silence table plus loudness run tracker reporting stable level runs.
//
// Channels: req_* carries one command per transfer (silence range load,
// loudness observation, or end-of-stream flush). rsp_* carries one run
// report per transfer. csr_* writes the level window, spread limit and
// minimum count; csr_ready is always high and writes belong to idle time.
// Flow: an observation walks the silence table, one table read per cycle.
// When a run is reported, the shared serial divider runs twice (mean, then
// stability) before the output register is loaded.
// Only one command is in work at a time; req_ready is high while idle.
// The result sits in an output register, so a new command is taken while
// a report waits; a second report waits for the first transfer.
// Reset: settings return to their defaults, the silence table is empty and
// no run is open; there is no clearing pass.
// ----------------------------------------------------------------------------
module stable_level_run_detector_top #(
   parameter int SILENCE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [slrd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [slrd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_opcode,
   input  logic [slrd_pkg::TAG_W-1:0]        req_source_tag,
   input  logic [slrd_pkg::TAG_W-1:0]        req_lineage_tag,
   input  logic [slrd_pkg::FRAME_W-1:0]      req_start_frame,
   input  logic [slrd_pkg::FRAME_W-1:0]      req_end_frame,
   input  logic [slrd_pkg::TIME_W-1:0]       req_pts_ms,
   input  logic [slrd_pkg::IV_W-1:0]         req_interval_ms,
   input  logic signed [slrd_pkg::LVL_W-1:0] req_level,
   input  logic signed [slrd_pkg::LVL_W-1:0] req_true_peak,
   input  logic                              req_peak_valid,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [slrd_pkg::TAG_W-1:0]        rsp_run_lineage,
   output logic [slrd_pkg::FRAME_W-1:0]      rsp_run_start,
   output logic [slrd_pkg::FRAME_W-1:0]      rsp_run_end,
   output logic [slrd_pkg::CNT_W-1:0]        rsp_run_length,
   output logic signed [slrd_pkg::LVL_W-1:0] rsp_level_mean,
   output logic signed [slrd_pkg::LVL_W-1:0] rsp_level_min,
   output logic signed [slrd_pkg::LVL_W-1:0] rsp_level_max,
   output logic [slrd_pkg::LVL_W-1:0]        rsp_level_spread,
   output logic [slrd_pkg::STAB_W-1:0]       rsp_stability,
   output logic signed [slrd_pkg::LVL_W-1:0] rsp_peak_max,
   output logic                              rsp_peak_seen
);
   import slrd_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   // sequencer
   slrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   slrd_datapath #(
      .SILENCE_DEPTH (SILENCE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_opcode       (req_opcode),
      .req_source_tag   (req_source_tag),
      .req_lineage_tag  (req_lineage_tag),
      .req_start_frame  (req_start_frame),
      .req_end_frame    (req_end_frame),
      .req_pts_ms       (req_pts_ms),
      .req_interval_ms  (req_interval_ms),
      .req_level        (req_level),
      .req_true_peak    (req_true_peak),
      .req_peak_valid   (req_peak_valid),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_run_lineage  (rsp_run_lineage),
      .rsp_run_start    (rsp_run_start),
      .rsp_run_end      (rsp_run_end),
      .rsp_run_length   (rsp_run_length),
      .rsp_level_mean   (rsp_level_mean),
      .rsp_level_min    (rsp_level_min),
      .rsp_level_max    (rsp_level_max),
      .rsp_level_spread (rsp_level_spread),
      .rsp_stability    (rsp_stability),
      .rsp_peak_max     (rsp_peak_max),
      .rsp_peak_seen    (rsp_peak_seen)
   );

endmodule
